@@ design/lcee_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the led channel effect engine
// no dependencies; used by lcee_chan_unit and led_channel_effect_engine
`default_nettype none

package lcee_pkg;

  localparam int CHANNELS_DEF = 48;

  localparam int ACTION_W = 2;
  localparam int CHAN_IN_W = 8;
  localparam int MODE_W = 3;
  localparam int BYTE_W = 8;
  localparam int LEVEL_W = 16;
  localparam int LEVEL_OUT_W = 12;
  localparam int OUT_CHAN_W = 6;
  localparam int STEP_W = 8;
  localparam int DUTY_W = 8;
  localparam int REG_INDEX_W = 2;
  localparam int REG_DATA_W = 12;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [LEVEL_OUT_W-1:0] LEVEL_MAX_RST = 12'hfff;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [REG_INDEX_W-1:0] REG_DUTY_WRAP  = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_DUTY_OFF   = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_LEVEL_MIN  = 2'd2;
  localparam logic [REG_INDEX_W-1:0] REG_LEVEL_MAX  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_HOLD          = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DUTY_ON       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DUTY_OFF      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SAW_UP        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SAW_DOWN      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SAW_UP_TRIG   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SAW_DOWN_TRIG = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic [DUTY_W-1:0]      duty_counter;
    logic [DUTY_W-1:0]      duty_off_point;
    logic [LEVEL_OUT_W-1:0] level_min;
    logic [LEVEL_OUT_W-1:0] level_max;
  } ctrl_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] level;
    logic [STEP_W-1:0]  step;
  } chan_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] level;
    logic               trig;
  } upd_t;

endpackage

`default_nettype wire

@@ design/lcee_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module lcee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/lcee_chan_unit.sv @@
`timescale 1ns / 1ps
// shared per-channel effect unit: duty toggle and saturating ramps
// depends on lcee_pkg
`default_nettype none

module lcee_chan_unit (
  input  wire lcee_pkg::ctrl_t ctrl,
  input  wire lcee_pkg::chan_t chan,
  output lcee_pkg::upd_t       upd
);
  import lcee_pkg::*;

  logic [LEVEL_W:0] up_sum;
  logic [LEVEL_W:0] dn_lim;
  logic             up_ok;
  logic             dn_ok;

  assign up_sum = {1'b0, chan.level} + {{(LEVEL_W+1-STEP_W){1'b0}}, chan.step};
  assign dn_lim = {{(LEVEL_W+1-LEVEL_OUT_W){1'b0}}, ctrl.level_min}
                + {{(LEVEL_W+1-STEP_W){1'b0}}, chan.step};
  assign up_ok = up_sum <= {{(LEVEL_W+1-LEVEL_OUT_W){1'b0}}, ctrl.level_max};
  assign dn_ok = {1'b0, chan.level} >= dn_lim;

  always_comb begin
    upd.mode  = chan.mode;
    upd.level = chan.level;
    upd.trig  = 1'b0;
    case (chan.mode)
      MODE_DUTY_ON: begin
        if (chan.step == ctrl.duty_counter) begin
          upd.level = {{(LEVEL_W-LEVEL_OUT_W){1'b0}}, ctrl.level_max};
          upd.mode  = MODE_DUTY_OFF;
        end
      end
      MODE_DUTY_OFF: begin
        if (ctrl.duty_off_point == ctrl.duty_counter) begin
          upd.level = {{(LEVEL_W-LEVEL_OUT_W){1'b0}}, ctrl.level_min};
          upd.mode  = MODE_DUTY_ON;
        end
      end
      MODE_SAW_UP, MODE_SAW_UP_TRIG: begin
        if (up_ok) begin
          upd.level = up_sum[LEVEL_W-1:0];
        end else begin
          upd.level = {{(LEVEL_W-LEVEL_OUT_W){1'b0}}, ctrl.level_max};
          upd.mode  = MODE_HOLD;
          upd.trig  = (chan.mode == MODE_SAW_UP_TRIG);
        end
      end
      MODE_SAW_DOWN, MODE_SAW_DOWN_TRIG: begin
        if (dn_ok) begin
          upd.level = chan.level - {{(LEVEL_W-STEP_W){1'b0}}, chan.step};
        end else begin
          upd.level = {{(LEVEL_W-LEVEL_OUT_W){1'b0}}, ctrl.level_min};
          upd.mode  = MODE_HOLD;
          upd.trig  = (chan.mode == MODE_SAW_DOWN_TRIG);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/led_channel_effect_engine.sv @@
`timescale 1ns / 1ps
// Per-channel LED effect engine. A write or clear transfer is answered by one acknowledge
// transfer with level 0, channel 0 and tlast set. A tick runs the shared channel unit over
// the channel memories, one channel a cycle, then reads every channel back through the read
// address shared by both memories, each channel passing the read state and then the load
// state, which waits while the output is stalled. All tick results carry the trigger flag
// as it stands after the whole pass. Input is taken only while the engine is idle.
// Depends on lcee_pkg, lcee_ram, lcee_chan_unit.
`default_nettype none

module led_channel_effect_engine #(
  parameter int CHANNELS = lcee_pkg::CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // channel[7:0], mode[10:8], value_high[18:11], value_low[26:19], zero fill
  input  wire logic [lcee_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action[1:0]
  input  wire logic [lcee_pkg::ACTION_W-1:0]       s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // level[11:0], out_channel[17:12], triggered[18], zero fill
  output logic      [lcee_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                     m_axis_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [lcee_pkg::REG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lcee_pkg::REG_DATA_W-1:0]     cfg_data
);
  import lcee_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(CHANNELS + 1);
  localparam int MS_W = MODE_W + STEP_W;
  localparam logic [CW-1:0] CNT_END = CW'(CHANNELS);
  localparam logic [CW-1:0] CNT_LAST = CW'(CHANNELS - 1);

  state_t state;
  state_t state_next;

  logic [DUTY_W-1:0]      duty_wrap;
  logic [DUTY_W-1:0]      duty_off_point;
  logic [LEVEL_OUT_W-1:0] level_min;
  logic [LEVEL_OUT_W-1:0] level_max;
  logic [DUTY_W-1:0]      duty_counter;
  logic [DUTY_W-1:0]      duty_inc;
  logic                   trigger;
  logic [CW-1:0]          cnt;

  logic [CHANNELS-1:0] lvl_valid;
  logic [CHANNELS-1:0] ms_valid;
  logic                lvl_rvalid;
  logic                ms_rvalid;

  logic [CHAN_IN_W-1:0] in_chan;
  logic [MODE_W-1:0]    in_mode;
  logic [BYTE_W-1:0]    in_vh;
  logic [BYTE_W-1:0]    in_vl;
  logic [ACTION_W-1:0]  in_action;
  logic                 in_xfer;
  logic                 in_chan_ok;
  logic                 in_saw;

  logic                 out_free;
  logic                 ack_load;
  logic                 emit_load;
  logic                 upd_we;
  logic                 host_ms_we;
  logic                 host_lvl_we;

  logic                 lvl_we;
  logic                 ms_we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [LEVEL_W-1:0]   lvl_wdata;
  logic [MS_W-1:0]      ms_wdata;
  logic [LEVEL_W-1:0]   lvl_q;
  logic [MS_W-1:0]      ms_q;

  ctrl_t ctrl;
  chan_t chan;
  upd_t  upd;

  logic                   out_valid;
  logic [LEVEL_OUT_W-1:0] out_level;
  logic [OUT_CHAN_W-1:0]  out_chan;
  logic                   out_last;
  logic                   out_trig;

  assign in_action  = s_axis_tuser;
  assign in_chan    = s_axis_tdata[7:0];
  assign in_mode    = s_axis_tdata[10:8];
  assign in_vh      = s_axis_tdata[18:11];
  assign in_vl      = s_axis_tdata[26:19];
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign in_chan_ok = in_chan < CHAN_IN_W'(CHANNELS);
  assign in_saw     = in_mode inside {[MODE_SAW_UP:MODE_SAW_DOWN_TRIG]};
  assign out_free   = !out_valid || m_axis_tready;
  assign duty_inc   = duty_counter + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && in_action == ACT_TICK) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (cnt == CNT_END) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          state_next = (cnt == CNT_LAST) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ack_load      = 1'b0;
    emit_load     = 1'b0;
    upd_we        = 1'b0;
    host_ms_we    = 1'b0;
    host_lvl_we   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = out_free;
        ack_load      = in_xfer && (in_action != ACT_TICK);
        host_ms_we    = in_xfer && (in_action == ACT_WRITE) && in_chan_ok;
        host_lvl_we   = host_ms_we && !in_saw;
      end
      ST_UPD: begin
        upd_we = (cnt != '0);
      end
      ST_EMIT_LD: begin
        emit_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign ms_we     = upd_we || host_ms_we;
  assign lvl_we    = upd_we || host_lvl_we;
  assign waddr     = upd_we ? AW'(cnt - 1'b1) : AW'(in_chan);
  assign raddr     = (cnt < CNT_END) ? AW'(cnt) : '0;
  assign lvl_wdata = upd_we ? upd.level : {in_vh, in_vl};
  assign ms_wdata  = upd_we ? {upd.mode, chan.step} : {in_mode, in_vl};

  assign chan.level = lvl_rvalid ? lvl_q : '0;
  assign chan.mode  = ms_rvalid ? ms_q[MS_W-1:STEP_W] : MODE_HOLD;
  assign chan.step  = ms_rvalid ? ms_q[STEP_W-1:0] : '0;

  assign ctrl.duty_counter   = duty_counter;
  assign ctrl.duty_off_point = duty_off_point;
  assign ctrl.level_min      = level_min;
  assign ctrl.level_max      = level_max;

  lcee_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (waddr),
    .wdata (lvl_wdata),
    .raddr (raddr),
    .rdata (lvl_q)
  );

  lcee_ram #(
    .WIDTH (MS_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_ms_ram (
    .clk   (clk),
    .we    (ms_we),
    .waddr (waddr),
    .wdata (ms_wdata),
    .raddr (raddr),
    .rdata (ms_q)
  );

  lcee_chan_unit u_chan_unit (
    .ctrl (ctrl),
    .chan (chan),
    .upd  (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      duty_wrap      <= '0;
      duty_off_point <= '0;
      level_min      <= '0;
      level_max      <= LEVEL_MAX_RST;
      duty_counter   <= '0;
      trigger        <= 1'b0;
      cnt            <= '0;
      lvl_valid      <= '0;
      ms_valid       <= '0;
      lvl_rvalid     <= 1'b0;
      ms_rvalid      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state      <= state_next;
      lvl_rvalid <= lvl_valid[raddr];
      ms_rvalid  <= ms_valid[raddr];
      if (cfg_we) begin
        case (cfg_index)
          REG_DUTY_WRAP:  duty_wrap      <= cfg_data[DUTY_W-1:0];
          REG_DUTY_OFF:   duty_off_point <= cfg_data[DUTY_W-1:0];
          REG_LEVEL_MIN:  level_min      <= cfg_data;
          REG_LEVEL_MAX:  level_max      <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_xfer && in_action == ACT_TICK) begin
        duty_counter <= (duty_inc >= duty_wrap) ? '0 : duty_inc;
        cnt          <= '0;
      end else if (state == ST_UPD) begin
        cnt <= (cnt == CNT_END) ? '0 : cnt + 1'b1;
      end else if (emit_load) begin
        cnt <= cnt + 1'b1;
      end
      if (ack_load && in_action == ACT_CLEAR) begin
        trigger <= 1'b0;
      end else if (upd_we && upd.trig) begin
        trigger <= 1'b1;
      end
      if (lvl_we) begin
        lvl_valid[waddr] <= 1'b1;
      end
      if (ms_we) begin
        ms_valid[waddr] <= 1'b1;
      end
      if (ack_load || emit_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (ack_load) begin
      out_level <= '0;
      out_chan  <= '0;
      out_last  <= 1'b1;
      out_trig  <= (in_action == ACT_CLEAR) ? 1'b0 : trigger;
    end else if (emit_load) begin
      out_level <= chan.level[LEVEL_OUT_W-1:0];
      out_chan  <= OUT_CHAN_W'(cnt);
      out_last  <= (cnt == CNT_LAST);
      out_trig  <= trigger;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {{(OUT_DATA_W-LEVEL_OUT_W-OUT_CHAN_W-1){1'b0}},
                          out_trig, out_chan, out_level};

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == ST_IDLE)
    else $error("input taken outside idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |-> cnt <= CNT_END)
    else $error("update counter out of range");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (emit_load && cnt == CNT_LAST) |=> state == ST_IDLE && out_valid && out_last)
    else $error("tick did not finish after last channel");

  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && out_chan != '0)
      |-> out_chan == OUT_CHAN_W'(CHANNELS - 1))
    else $error("tlast on wrong channel");
`endif

endmodule

`default_nettype wire
